[design/tgr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_pkg
// shared constants for the text glyph row renderer: sizes, register
// indexes, reset values, item kinds and control character codes
// ----------------------------------------------------------------------------
package tgr_pkg;

	// default store geometry
	localparam int MAX_GLYPHS_DEF = 256;
	localparam int MAX_ROWS_DEF   = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd4;

	// register reset values
	localparam logic [3:0]  GLYPH_WIDTH_RST  = 4'd8;
	localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
	localparam logic [15:0] LINE_PITCH_RST   = 16'd4096;
	localparam logic [8:0]  GLYPH_COUNT_RST  = 9'd256;
	localparam logic [29:0] FRAME_BASE_RST   = 30'd0;

	// item kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// control characters
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// widest glyph row
	localparam int MAX_WIDTH = 8;

endpackage
`default_nettype wire

[design/tgr_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_in_if
// input item channel: glyph row loads and characters
// ----------------------------------------------------------------------------
interface tgr_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;
	logic [4:0] row_index;
	logic [7:0] row_bits;

	modport source (output valid, output kind, output char_code, output row_index,
		output row_bits, input ready);
	modport sink (input valid, input kind, input char_code, input row_index,
		input row_bits, output ready);
endinterface
`default_nettype wire

[design/tgr_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_out_if
// result channel: one framebuffer row write per transfer
// ----------------------------------------------------------------------------
interface tgr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_address;
	logic [7:0]  row_pixels;
	logic        last_row;

	modport source (output valid, output pixel_address, output row_pixels,
		output last_row, input ready);
	modport sink (input valid, input pixel_address, input row_pixels,
		input last_row, output ready);
endinterface
`default_nettype wire

[design/tgr_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface tgr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tgr_pkg::CFG_IDX_W-1:0]  index;
	logic [tgr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/text_glyph_row_renderer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_glyph_row_renderer_top
// text console renderer: draws characters from a loadable bitmap font as
// framebuffer row writes
// ----------------------------------------------------------------------------
// usage
//  - cfg: register writes (glyph_width, glyph_height, line_pitch, glyph_count,
//    frame_base), always ready; write only while the block is idle
//  - item: one transfer per input item; kind 1 loads one glyph row into the
//    font store in the cycle it is taken, kind 0 is a character
//  - carriage return and line feed only move the cursor, no result
//  - a printable character gives glyph_height (clamped to 1..MAX_ROWS) result transfers on result,
//    top row first, last_row set on the final one
//  - the first result follows the character transfer through the ST_MUL and
//    ST_SUM address setup states, a font store read and the output register
//  - rows leave the font store read port at one row per cycle while result
//    is not stalled; loads and control characters leave item.ready high
//  - item.ready drops while a character is being expanded and rises again
//    once its last row sits in the output register
//  - a stalled result holds the output register and the font read pipeline
//  - reset clears the cursor, the registers to their defaults and all
//    handshake state; the font store is undefined until loaded
// ----------------------------------------------------------------------------
module text_glyph_row_renderer_top #(
	parameter int MAX_GLYPHS = tgr_pkg::MAX_GLYPHS_DEF,
	parameter int MAX_ROWS   = tgr_pkg::MAX_ROWS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tgr_cfg_if.sink   cfg,
	tgr_in_if.sink    item,
	tgr_out_if.source result
);

	localparam int DEPTH = MAX_GLYPHS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GW    = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = $clog2(MAX_ROWS + 1);

	// one-hot sequencer
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_ROWS = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [3:0]  gwidth_q;
	logic [5:0]  gheight_q;
	logic [15:0] pitch_q;
	logic [8:0]  gcount_q;
	logic [29:0] base_q;

	// cursor
	logic [15:0] col_q;
	logic [15:0] row_q;

	// per-character context
	logic [GW-1:0] glyph_q;
	logic [CW-1:0] h_q;
	logic [7:0]    mask_q;
	logic [21:0]   rh_s1;
	logic [19:0]   coloff_s1;
	logic [31:0]   rowoff_s2;
	logic [31:0]   addr_q;
	logic [CW-1:0] issue_q;
	logic [CW-1:0] emit_q;
	logic          pend_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_addr_q;
	logic [7:0]  out_pix_q;
	logic        out_last_q;

	// font store ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	logic          in_xfer;
	logic          cfg_xfer;
	logic          is_print;
	logic          load_ok;
	logic [3:0]    w_eff;
	logic [CW-1:0] h_eff;
	logic [GW-1:0] glyph_sel;
	logic          fire;
	logic          out_load;
	logic          is_last;

	// ---------------------------------------------------------------- handshakes
	assign cfg.ready  = 1'b1;
	assign cfg_xfer   = cfg.valid;
	assign item.ready = (state_q == ST_IDLE);
	assign in_xfer    = item.valid && item.ready;

	assign is_print = (item.kind == tgr_pkg::KIND_CHAR) && (item.char_code != tgr_pkg::CH_CR)
		&& (item.char_code != tgr_pkg::CH_LF);

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gwidth_q  <= tgr_pkg::GLYPH_WIDTH_RST;
			gheight_q <= tgr_pkg::GLYPH_HEIGHT_RST;
			pitch_q   <= tgr_pkg::LINE_PITCH_RST;
			gcount_q  <= tgr_pkg::GLYPH_COUNT_RST;
			base_q    <= tgr_pkg::FRAME_BASE_RST;
		end else if (cfg_xfer) begin
			case (cfg.index)
				tgr_pkg::REG_GLYPH_WIDTH:  gwidth_q  <= cfg.data[3:0];
				tgr_pkg::REG_GLYPH_HEIGHT: gheight_q <= cfg.data[5:0];
				tgr_pkg::REG_LINE_PITCH:   pitch_q   <= cfg.data[15:0];
				tgr_pkg::REG_GLYPH_COUNT:  gcount_q  <= cfg.data[8:0];
				tgr_pkg::REG_FRAME_BASE:   base_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// clamp width to 1..8 and height to 1..MAX_ROWS
	always_comb begin
		if (gwidth_q == 4'd0) begin
			w_eff = 4'd1;
		end else if (int'(gwidth_q) > tgr_pkg::MAX_WIDTH) begin
			w_eff = 4'(tgr_pkg::MAX_WIDTH);
		end else begin
			w_eff = gwidth_q;
		end
		if (gheight_q == 6'd0) begin
			h_eff = CW'(1);
		end else if (int'(gheight_q) > MAX_ROWS) begin
			h_eff = CW'(MAX_ROWS);
		end else begin
			h_eff = CW'(gheight_q);
		end
	end

	// codes past the loaded font fall back to glyph 0
	assign glyph_sel = ({1'b0, item.char_code} < gcount_q
		&& 9'(item.char_code) < 9'(MAX_GLYPHS)) ? GW'(item.char_code) : '0;

	// ---------------------------------------------------------------- font loads
	assign load_ok   = 9'(item.char_code) < 9'(MAX_GLYPHS)
		&& 6'(item.row_index) < 6'(MAX_ROWS);
	assign mem_we    = in_xfer && (item.kind == tgr_pkg::KIND_LOAD) && load_ok;
	assign mem_waddr = AW'(AW'(GW'(item.char_code)) * AW'(MAX_ROWS) + AW'(item.row_index));

	// ---------------------------------------------------------------- cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer && item.kind == tgr_pkg::KIND_CHAR) begin
			if (item.char_code == tgr_pkg::CH_CR) begin
				col_q <= '0;
			end else if (item.char_code == tgr_pkg::CH_LF) begin
				col_q <= '0;
				row_q <= row_q + 16'd1;
			end else begin
				col_q <= col_q + 16'd1;
			end
		end
	end

	// ---------------------------------------------------------------- address setup
	// stage 1 multiplies take the cursor before it advances
	always_ff @(posedge clk) begin
		if (in_xfer && is_print) begin
			rh_s1     <= 22'(row_q) * 22'(h_eff);
			coloff_s1 <= 20'(col_q) * 20'({1'b0, w_eff} + 5'd1);
			glyph_q   <= glyph_sel;
			h_q       <= h_eff;
			mask_q    <= 8'((9'd1 << w_eff) - 9'd1);
		end
		if (state_q == ST_MUL) begin
			rowoff_s2 <= 32'(rh_s1 * 38'(pitch_q));
		end
	end

	// ---------------------------------------------------------------- row readout
	// fire: the output register is free or being emptied this cycle
	assign fire     = !out_valid_q || result.ready;
	assign out_load = (state_q == ST_ROWS) && pend_q && fire;
	assign is_last  = (emit_q + CW'(1)) == h_q;
	assign mem_re   = (state_q == ST_ROWS) && (issue_q < h_q) && (!pend_q || fire);
	assign mem_raddr = AW'(AW'(glyph_q) * AW'(MAX_ROWS) + AW'(issue_q[RW-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= '0;
			emit_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && is_print) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					issue_q <= '0;
					emit_q  <= '0;
					pend_q  <= 1'b0;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (mem_re) begin
						issue_q <= issue_q + CW'(1);
						pend_q  <= 1'b1;
					end else if (out_load) begin
						pend_q  <= 1'b0;
					end
					if (out_load) begin
						emit_q <= emit_q + CW'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// running row address, one line pitch per row
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			addr_q <= 32'(base_q) + rowoff_s2 + 32'({coloff_s1, 2'b00});
		end else if (out_load) begin
			addr_q <= addr_q + 32'(pitch_q);
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q <= addr_q;
			out_pix_q  <= mem_rdata & mask_q;
			out_last_q <= is_last;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.pixel_address = out_addr_q;
	assign result.row_pixels    = out_pix_q;
	assign result.last_row      = out_last_q;

	// ---------------------------------------------------------------- font store
	tgr_font_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_font (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (item.row_bits),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	// a row waiting in the read register is never overwritten
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROWS) && pend_q && !fire |=> pend_q && $stable(mem_rdata))
		else $error("pending font row lost");

	// rows are never emitted ahead of their reads
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q <= issue_q)
		else $error("row emitted before read");

	// a printable character starts the address setup
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && is_print |=> state_q == ST_MUL)
		else $error("character not started");

	// the final row ends the character
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && is_last |=> state_q == ST_IDLE && result.last_row)
		else $error("sequencer not idle after last row");

	// no font read is issued after the final row of a character
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROWS && out_load && is_last |=> !mem_re)
		else $error("read issued after last row");
`endif

endmodule
`default_nettype wire

[design/tgr_font_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_font_mem
// font store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tgr_font_mem #(
	parameter int DEPTH = tgr_pkg::MAX_GLYPHS_DEF * tgr_pkg::MAX_ROWS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
